>>> rtl/core/dsfp_pkg.sv
`timescale 1ns / 1ps

package dsfp_pkg;

    // default parameter values
    localparam int DEF_MAX_FRAME_BYTES  = 256;
    localparam int DEF_MAX_FIELD_DIGITS = 4;
    localparam int DEF_NUM_OUT_FIELDS   = 10;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int SEPCNT_W  = 4;
    localparam int VALUE_W   = 14;
    localparam int INDEX_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 9'd511;
    localparam logic [SEPCNT_W-1:0] SEPCNT_MAX = 4'd15;
    localparam logic [VALUE_W-1:0]  VALUE_MAX  = 14'd16383;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FIELDS = 2'd2;

    localparam logic [BYTE_W-1:0]   RST_SEPARATOR  = 8'd62;
    localparam logic [COUNT_W-1:0]  RST_MIN_BYTES  = 9'd21;
    localparam logic [SEPCNT_W-1:0] RST_MIN_FIELDS = 4'd11;

    // characters of interest
    localparam logic [BYTE_W-1:0] CHAR_B    = 8'h42;
    localparam logic [BYTE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_T    = 8'h54;
    localparam logic [BYTE_W-1:0] CHAR_H    = 8'h48;
    localparam logic [BYTE_W-1:0] CHAR_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;

    typedef enum logic [1:0] {
        BAT_IDLE,
        BAT_B,
        BAT_BA
    } bat_state_t;

    typedef enum logic [1:0] {
        HASH_START,
        HASH_H,
        HASH_HH,
        HASH_MISS
    } hash_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic valid;
        logic bad;
    } job_ctl_t;

    typedef struct packed {
        logic [INDEX_W-1:0] field_index;
        logic [VALUE_W-1:0] field_value;
        logic               frame_status;
        logic               last_of_frame;
    } result_t;

endpackage

>>> rtl/core/delimited_sensor_frame_parser.sv
`timescale 1ns / 1ps

// Parses one text frame of a sound meter, one byte per request, fields split by the
// separator register. A byte is taken every cycle unless full is high; full is high, for
// any byte, while the two-entry frame queue holds two frames whose results have not all
// been handed to the result queue yet.
// At the terminator a good frame yields NUM_OUT_FIELDS results, a bad one a single
// result with frame_status set, an init frame ("BAT" among its parsed bytes) none. The result
// side picks up a queued frame and writes its results in order into the two-entry result
// queue in front of pop, waiting while that queue is full. No clearing pass follows reset.
module delimited_sensor_frame_parser #(
    parameter int MAX_FRAME_BYTES  = dsfp_pkg::DEF_MAX_FRAME_BYTES,
    parameter int MAX_FIELD_DIGITS = dsfp_pkg::DEF_MAX_FIELD_DIGITS,
    parameter int NUM_OUT_FIELDS   = dsfp_pkg::DEF_NUM_OUT_FIELDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [dsfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsfp_pkg::CFG_W-1:0]        cfg_data,
    input  logic [dsfp_pkg::BYTE_W-1:0]       rx_byte,
    input  logic                              frame_end,
    input  logic                              push,
    output logic                              full,
    output logic [dsfp_pkg::INDEX_W-1:0]      field_index,
    output logic [dsfp_pkg::VALUE_W-1:0]      field_value,
    output logic                              frame_status,
    output logic                              last_of_frame,
    output logic                              empty,
    input  logic                              pop
);

    dsfp_pkg::job_ctl_t                               fr_ctl, bk_ctl;
    logic [NUM_OUT_FIELDS-1:0][dsfp_pkg::VALUE_W-1:0] fr_values, bk_values;
    logic                                             q_ready, bk_pop;
    dsfp_pkg::result_t                                head;

    dsfp_front #(
        .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
        .MAX_FIELD_DIGITS (MAX_FIELD_DIGITS),
        .NUM_OUT_FIELDS   (NUM_OUT_FIELDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .frame_end  (frame_end),
        .push       (push),
        .full       (full),
        .job_ready  (q_ready),
        .job_ctl    (fr_ctl),
        .job_values (fr_values)
    );

    dsfp_jobq #(
        .NUM_OUT_FIELDS (NUM_OUT_FIELDS)
    ) u_jobq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (fr_ctl),
        .in_values  (fr_values),
        .in_ready   (q_ready),
        .out_ctl    (bk_ctl),
        .out_values (bk_values),
        .out_pop    (bk_pop)
    );

    dsfp_back #(
        .NUM_OUT_FIELDS (NUM_OUT_FIELDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_ctl    (bk_ctl),
        .job_values (bk_values),
        .job_pop    (bk_pop),
        .res_head   (head),
        .empty      (empty),
        .pop        (pop)
    );

    assign field_index   = head.field_index;
    assign field_value   = head.field_value;
    assign frame_status  = head.frame_status;
    assign last_of_frame = head.last_of_frame;

endmodule

>>> rtl/core/dsfp_front.sv
`timescale 1ns / 1ps

module dsfp_front #(
    parameter int MAX_FRAME_BYTES  = dsfp_pkg::DEF_MAX_FRAME_BYTES,
    parameter int MAX_FIELD_DIGITS = dsfp_pkg::DEF_MAX_FIELD_DIGITS,
    parameter int NUM_OUT_FIELDS   = dsfp_pkg::DEF_NUM_OUT_FIELDS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [dsfp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dsfp_pkg::CFG_W-1:0]             cfg_data,
    input  logic [dsfp_pkg::BYTE_W-1:0]            rx_byte,
    input  logic                                   frame_end,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   job_ready,
    output dsfp_pkg::job_ctl_t                     job_ctl,
    output logic [NUM_OUT_FIELDS-1:0][dsfp_pkg::VALUE_W-1:0] job_values
);

    localparam int FP_W = $clog2(NUM_OUT_FIELDS + 1);
    localparam int CH_W = $clog2(MAX_FIELD_DIGITS + 1);
    localparam logic [31:0] PARSE_LIMIT = 32'(MAX_FRAME_BYTES - 1);

    logic [dsfp_pkg::BYTE_W-1:0]   sep_reg;
    logic [dsfp_pkg::COUNT_W-1:0]  min_bytes_reg;
    logic [dsfp_pkg::SEPCNT_W-1:0] min_fields_reg;

    logic [dsfp_pkg::COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [dsfp_pkg::SEPCNT_W-1:0] sep_count_reg, sep_count_next;
    logic [FP_W-1:0]               field_pos_reg, field_pos_next;
    logic [CH_W-1:0]               chars_reg, chars_next;
    logic                          stopped_reg, stopped_next;
    logic [dsfp_pkg::VALUE_W-1:0]  acc_reg, acc_next;
    dsfp_pkg::bat_state_t          bat_reg, bat_next;
    logic                          bat_seen_reg, bat_seen_next;
    dsfp_pkg::hash_state_t         hash_reg, hash_next;
    logic [dsfp_pkg::VALUE_W-1:0]  store_reg [NUM_OUT_FIELDS];

    logic                          accept;
    logic                          parse_en;
    logic                          is_sep;
    logic                          is_digit;
    logic                          store_wr;
    logic                          bad;
    logic [dsfp_pkg::COUNT_W-1:0]  byte_inc;
    logic [dsfp_pkg::BYTE_W-1:0]   digit_val;
    logic [17:0]                   acc_mul;

    assign full     = !job_ready;
    assign accept   = push && !full;
    assign parse_en = {23'd0, byte_count_reg} < PARSE_LIMIT;
    assign is_sep   = rx_byte == sep_reg;
    assign is_digit = rx_byte inside {[dsfp_pkg::CHAR_0:dsfp_pkg::CHAR_9]};
    assign byte_inc = (byte_count_reg == dsfp_pkg::COUNT_MAX) ? byte_count_reg
                                                              : byte_count_reg + 9'd1;
    assign digit_val = rx_byte - dsfp_pkg::CHAR_0;
    // acc * 10 + digit as shift-add
    assign acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {14'd0, digit_val[3:0]};

    assign bad = (byte_inc < min_bytes_reg)
              || (({1'b0, sep_count_reg} + 5'd1) < {1'b0, min_fields_reg})
              || (hash_reg == dsfp_pkg::HASH_HH);

    assign store_wr = accept && !frame_end && parse_en && is_sep
                   && (field_pos_reg < FP_W'(NUM_OUT_FIELDS)) && (field_pos_reg != '0);

    assign job_ctl.valid = accept && frame_end && !bat_seen_reg;
    assign job_ctl.bad   = bad;

    always_comb
    begin
        for (int k = 0; k < NUM_OUT_FIELDS; k++)
        begin
            if (FP_W'(k + 1) < field_pos_reg)
                job_values[k] = store_reg[k];
            else if (FP_W'(k + 1) == field_pos_reg)
                job_values[k] = acc_reg;
            else
                job_values[k] = '0;
        end
    end

    always_comb
    begin
        byte_count_next = byte_count_reg;
        sep_count_next  = sep_count_reg;
        field_pos_next  = field_pos_reg;
        chars_next      = chars_reg;
        stopped_next    = stopped_reg;
        acc_next        = acc_reg;
        bat_next        = bat_reg;
        bat_seen_next   = bat_seen_reg;
        hash_next       = hash_reg;

        if (accept)
        begin
            if (frame_end)
            begin
                byte_count_next = '0;
                sep_count_next  = '0;
                field_pos_next  = '0;
                chars_next      = '0;
                stopped_next    = 1'b0;
                acc_next        = '0;
                bat_next        = dsfp_pkg::BAT_IDLE;
                bat_seen_next   = 1'b0;
                hash_next       = dsfp_pkg::HASH_START;
            end
            else
            begin
                byte_count_next = byte_inc;
                if (parse_en)
                begin
                    // "BAT" has no self-overlap; a 'B' always restarts the match
                    if (rx_byte == dsfp_pkg::CHAR_B)
                        bat_next = dsfp_pkg::BAT_B;
                    else if (bat_reg == dsfp_pkg::BAT_B && rx_byte == dsfp_pkg::CHAR_A)
                        bat_next = dsfp_pkg::BAT_BA;
                    else
                    begin
                        if (bat_reg == dsfp_pkg::BAT_BA && rx_byte == dsfp_pkg::CHAR_T)
                            bat_seen_next = 1'b1;
                        bat_next = dsfp_pkg::BAT_IDLE;
                    end

                    case (hash_reg)
                        dsfp_pkg::HASH_START:
                            hash_next = (rx_byte == dsfp_pkg::CHAR_H) ? dsfp_pkg::HASH_H
                                                                      : dsfp_pkg::HASH_MISS;
                        dsfp_pkg::HASH_H:
                            hash_next = (rx_byte == dsfp_pkg::CHAR_HASH) ? dsfp_pkg::HASH_HH
                                                                         : dsfp_pkg::HASH_MISS;
                        default:
                            hash_next = dsfp_pkg::HASH_MISS;
                    endcase

                    if (is_sep)
                    begin
                        if (sep_count_reg != dsfp_pkg::SEPCNT_MAX)
                            sep_count_next = sep_count_reg + 4'd1;
                        if (field_pos_reg < FP_W'(NUM_OUT_FIELDS))
                        begin
                            field_pos_next = field_pos_reg + FP_W'(1);
                            chars_next     = '0;
                            stopped_next   = 1'b0;
                            acc_next       = '0;
                        end
                        else
                            stopped_next = 1'b1;
                    end
                    else if (field_pos_reg != '0 && chars_reg < CH_W'(MAX_FIELD_DIGITS))
                    begin
                        chars_next = chars_reg + CH_W'(1);
                        if (!stopped_reg)
                        begin
                            if (is_digit)
                                acc_next = (acc_mul > {4'd0, dsfp_pkg::VALUE_MAX})
                                         ? dsfp_pkg::VALUE_MAX : acc_mul[dsfp_pkg::VALUE_W-1:0];
                            else
                                stopped_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg        <= dsfp_pkg::RST_SEPARATOR;
            min_bytes_reg  <= dsfp_pkg::RST_MIN_BYTES;
            min_fields_reg <= dsfp_pkg::RST_MIN_FIELDS;
            byte_count_reg <= '0;
            sep_count_reg  <= '0;
            field_pos_reg  <= '0;
            chars_reg      <= '0;
            stopped_reg    <= 1'b0;
            acc_reg        <= '0;
            bat_reg        <= dsfp_pkg::BAT_IDLE;
            bat_seen_reg   <= 1'b0;
            hash_reg       <= dsfp_pkg::HASH_START;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    dsfp_pkg::REG_SEPARATOR:  sep_reg        <= cfg_data[dsfp_pkg::BYTE_W-1:0];
                    dsfp_pkg::REG_MIN_BYTES:  min_bytes_reg  <= cfg_data;
                    dsfp_pkg::REG_MIN_FIELDS: min_fields_reg <= cfg_data[dsfp_pkg::SEPCNT_W-1:0];
                    default: ;
                endcase
            end
            byte_count_reg <= byte_count_next;
            sep_count_reg  <= sep_count_next;
            field_pos_reg  <= field_pos_next;
            chars_reg      <= chars_next;
            stopped_reg    <= stopped_next;
            acc_reg        <= acc_next;
            bat_reg        <= bat_next;
            bat_seen_reg   <= bat_seen_next;
            hash_reg       <= hash_next;
        end
    end

    // field k is closed by the separator that moves field_pos from k+1 to k+2
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_OUT_FIELDS; i++)
        begin
            if (store_wr && field_pos_reg == FP_W'(i + 1))
                store_reg[i] <= acc_reg;
        end
    end

endmodule

>>> rtl/core/dsfp_jobq.sv
`timescale 1ns / 1ps

module dsfp_jobq #(
    parameter int NUM_OUT_FIELDS = dsfp_pkg::DEF_NUM_OUT_FIELDS
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  dsfp_pkg::job_ctl_t                               in_ctl,
    input  logic [NUM_OUT_FIELDS-1:0][dsfp_pkg::VALUE_W-1:0] in_values,
    output logic                                             in_ready,
    output dsfp_pkg::job_ctl_t                               out_ctl,
    output logic [NUM_OUT_FIELDS-1:0][dsfp_pkg::VALUE_W-1:0] out_values,
    input  logic                                             out_pop
);

    logic                                             bad_reg [2];
    logic [NUM_OUT_FIELDS-1:0][dsfp_pkg::VALUE_W-1:0] val_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       wr_en, rd_en;

    assign in_ready      = count_reg != 2'd2;
    assign wr_en         = in_ctl.valid && in_ready;
    assign rd_en         = out_pop && count_reg != 2'd0;
    assign out_ctl.valid = count_reg != 2'd0;
    assign out_ctl.bad   = bad_reg[rd_ptr_reg];
    assign out_values    = val_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bad_reg[wr_ptr_reg] <= in_ctl.bad;
            val_reg[wr_ptr_reg] <= in_values;
        end
    end

endmodule

>>> rtl/core/dsfp_back.sv
`timescale 1ns / 1ps

module dsfp_back #(
    parameter int NUM_OUT_FIELDS = dsfp_pkg::DEF_NUM_OUT_FIELDS
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  dsfp_pkg::job_ctl_t                               job_ctl,
    input  logic [NUM_OUT_FIELDS-1:0][dsfp_pkg::VALUE_W-1:0] job_values,
    output logic                                             job_pop,
    output dsfp_pkg::result_t                                res_head,
    output logic                                             empty,
    input  logic                                             pop
);

    localparam int K_W = (NUM_OUT_FIELDS > 1) ? $clog2(NUM_OUT_FIELDS) : 1;

    dsfp_pkg::back_state_t state_reg, state_next;
    logic [K_W-1:0]        k_reg, k_next;

    dsfp_pkg::result_t     mem_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            count_reg, count_next;
    logic                  rd_en, room, res_wr, res_last;
    dsfp_pkg::result_t     res_new;

    assign rd_en    = pop && count_reg != 2'd0;
    assign room     = count_reg != 2'd2 || rd_en;
    assign empty    = count_reg == 2'd0;
    assign res_head = mem_reg[rd_ptr_reg];
    assign res_last = job_ctl.bad || k_reg == K_W'(NUM_OUT_FIELDS - 1);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            dsfp_pkg::BK_IDLE:
            begin
                if (job_ctl.valid)
                    state_next = dsfp_pkg::BK_EMIT;
            end
            dsfp_pkg::BK_EMIT:
            begin
                if (room)
                begin
                    if (res_last)
                    begin
                        k_next     = '0;
                        state_next = dsfp_pkg::BK_IDLE;
                    end
                    else
                        k_next = k_reg + K_W'(1);
                end
            end
            default:
                state_next = dsfp_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        res_wr  = 1'b0;
        job_pop = 1'b0;
        res_new.field_index   = job_ctl.bad ? '0 : dsfp_pkg::INDEX_W'(k_reg);
        res_new.field_value   = job_ctl.bad ? '0 : job_values[k_reg];
        res_new.frame_status  = job_ctl.bad;
        res_new.last_of_frame = res_last;
        case (state_reg)
            dsfp_pkg::BK_EMIT:
            begin
                res_wr  = room;
                job_pop = room && res_last;
            end
            default:
            begin
                res_wr  = 1'b0;
                job_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (res_wr && !rd_en)
            count_next = count_reg + 2'd1;
        else if (!res_wr && rd_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dsfp_pkg::BK_IDLE;
            k_reg      <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (res_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
            mem_reg[wr_ptr_reg] <= res_new;
    end

endmodule

>>> rtl/core/dsfp_checker.sv
`timescale 1ns / 1ps

module dsfp_checker #(
    parameter int NUM_OUT_FIELDS = dsfp_pkg::DEF_NUM_OUT_FIELDS
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic [dsfp_pkg::INDEX_W-1:0] field_index,
    input logic [dsfp_pkg::VALUE_W-1:0] field_value,
    input logic                         frame_status,
    input logic                         last_of_frame,
    input logic                         empty,
    input logic                         pop
);

    // a bad-frame result stands alone and carries zeros
    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && frame_status |-> last_of_frame && field_value == '0 && field_index == '0)
        else $error("bad-frame result malformed");

    // good results stay in range; only the top index closes the frame
    a_good_index: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !frame_status |->
            field_index <= dsfp_pkg::INDEX_W'(NUM_OUT_FIELDS - 1)
            && (last_of_frame == (field_index == dsfp_pkg::INDEX_W'(NUM_OUT_FIELDS - 1))))
        else $error("good result index out of range");

    // within a good frame the next index follows right after the pop
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !frame_status && !last_of_frame |=>
            !empty && !frame_status && field_index == $past(field_index) + 4'd1)
        else $error("field index did not advance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(field_value) && $stable(field_index))
        else $error("waiting result changed");

endmodule

bind delimited_sensor_frame_parser dsfp_checker #(
    .NUM_OUT_FIELDS (NUM_OUT_FIELDS)
) u_dsfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .field_index   (field_index),
    .field_value   (field_value),
    .frame_status  (frame_status),
    .last_of_frame (last_of_frame),
    .empty         (empty),
    .pop           (pop)
);
